/* hdl/rgmb_pkg.sv */
// Shared types and constants of the rolling grid map buffer.
// Used by the front end, the queue, the back end and the top level.
package rgmb_pkg;

	// Input mode codes as they arrive on the stream.
	localparam logic [2:0] MODE_READ  = 3'd0;
	localparam logic [2:0] MODE_WRITE = 3'd1;
	localparam logic [2:0] MODE_EAST  = 3'd2;
	localparam logic [2:0] MODE_NORTH = 3'd3;
	localparam logic [2:0] MODE_SOUTH = 3'd4;
	localparam logic [2:0] MODE_WEST  = 3'd5;

	// Decoded operation of a queued item.
	typedef enum logic [2:0] {
		OP_READ,
		OP_WRITE,
		OP_EAST,
		OP_NORTH,
		OP_SOUTH,
		OP_WEST
	} op_t;

	// One decoded item as it travels from front end to back end.
	typedef struct packed {
		op_t         op;
		logic [31:0] easting;
		logic [31:0] northing;
		logic [7:0]  value;
	} item_t;

	// Configuration register indexes.
	localparam int CFG_INDEX_W = 2;
	localparam int CFG_DATA_W  = 32;
	localparam logic [CFG_INDEX_W-1:0] CFG_ORIGIN_EAST   = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] CFG_ORIGIN_NORTH  = 2'd1;
	localparam logic [CFG_INDEX_W-1:0] CFG_DEFAULT_VALUE = 2'd2;

	// Result kinds.
	localparam logic KIND_ACCESS = 1'b0;
	localparam logic KIND_SWAP   = 1'b1;

	// Stream widths.
	localparam int IN_TDATA_W  = 72;
	localparam int OUT_TDATA_W = 152;

	// Decoupling queue between front and back end.
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = 2;

	// Back end sequencer states.
	typedef enum logic [1:0] {
		BK_CLEAR,
		BK_RUN,
		BK_SCROLL
	} back_state_t;

	// Payload of a sector swap request.
	typedef struct packed {
		logic [7:0]  slot;
		logic [31:0] save_east;
		logic [31:0] save_north;
		logic [31:0] load_east;
		logic [31:0] load_north;
	} swap_t;

endpackage

/* hdl/rgmb_ram.sv */
// Generic simple dual-port RAM with one write port and one registered read port.
// Standalone; no package needed.
module rgmb_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256,
	localparam int ADDR_W = $clog2(DEPTH)
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [WIDTH-1:0]  wdata,
	input  logic              re,
	input  logic [ADDR_W-1:0] raddr,
	output logic [WIDTH-1:0]  rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port and registered read port; the read data holds while re is low.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

/* hdl/rgmb_front.sv */
// Front end: takes input items, decodes the mode and registers one item for the queue.
// Depends on rgmb_pkg.
module rgmb_front (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             clearing,
	input  logic                             s_tvalid,
	output logic                             s_tready,
	input  logic [2:0]                       s_tuser,  // mode
	input  logic [rgmb_pkg::IN_TDATA_W-1:0]  s_tdata,  // easting, northing, value
	output logic                             q_valid,
	input  logic                             q_ready,
	output rgmb_pkg::item_t                  q_item
);
	import rgmb_pkg::*;

	logic  valid_q;
	item_t item_q;
	logic  dec_ok;
	op_t   dec_op;

	// Map the mode code to an operation; unused codes are dropped.
	always_comb begin
		dec_ok = 1'b1;
		dec_op = OP_READ;
		unique case (s_tuser)
			MODE_READ:  dec_op = OP_READ;
			MODE_WRITE: dec_op = OP_WRITE;
			MODE_EAST:  dec_op = OP_EAST;
			MODE_NORTH: dec_op = OP_NORTH;
			MODE_SOUTH: dec_op = OP_SOUTH;
			MODE_WEST:  dec_op = OP_WEST;
			default:    dec_ok = 1'b0;
		endcase
	end

	// No item is taken while the store is being cleared.
	assign s_tready = !clearing && (!valid_q || q_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (s_tready) begin
			valid_q <= s_tvalid && dec_ok;
		end else if (q_ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			item_q.op       <= dec_op;
			item_q.easting  <= s_tdata[31:0];
			item_q.northing <= s_tdata[63:32];
			item_q.value    <= s_tdata[71:64];
		end
	end

	assign q_valid = valid_q;
	assign q_item  = item_q;

endmodule

/* hdl/rgmb_queue.sv */
// Short item queue that decouples the front end from the back end.
// Depends on rgmb_pkg.
module rgmb_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	input  rgmb_pkg::item_t in_item,
	output logic            out_valid,
	input  logic            out_ready,
	output rgmb_pkg::item_t out_item
);
	import rgmb_pkg::*;

	item_t             entries_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_q;
	logic [QPTR_W-1:0] rd_q;
	logic [QPTR_W:0]   count_q;
	logic              push;
	logic              pop;

	assign in_ready  = count_q != (QPTR_W + 1)'(QUEUE_DEPTH);
	assign out_valid = count_q != '0;
	assign out_item  = entries_q[rd_q];
	assign push      = in_valid && in_ready;
	assign pop       = out_valid && out_ready;

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + QPTR_W'(1);
			end
			if (pop) begin
				rd_q <= rd_q + QPTR_W'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + (QPTR_W + 1)'(1);
			end else if (pop && !push) begin
				count_q <= count_q - (QPTR_W + 1)'(1);
			end
		end
	end

	// Entry storage.
	always_ff @(posedge clk) begin
		if (push) begin
			entries_q[wr_q] <= in_item;
		end
	end

endmodule

/* hdl/rgmb_back.sv */
// Back end: view state, scroll sequencer, access address pipeline and the cell store.
// Depends on rgmb_pkg and rgmb_ram.
module rgmb_back #(
	parameter int SECTORS_ACROSS      = 4,
	parameter int CELLS_ACROSS_SECTOR = 64,
	parameter int CELL_METERS         = 1
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_wen,
	input  logic [rgmb_pkg::CFG_INDEX_W-1:0]  cfg_index,
	input  logic [rgmb_pkg::CFG_DATA_W-1:0]   cfg_data,
	input  logic                              q_valid,
	output logic                              q_ready,
	input  rgmb_pkg::item_t                   q_item,
	output logic                              clearing,
	output logic                              m_tvalid,
	input  logic                              m_tready,
	output logic                              m_tuser,  // kind
	// cell_value, in_view, sector_slot, save_east, save_north, load_east, load_north
	output logic [rgmb_pkg::OUT_TDATA_W-1:0]  m_tdata,
	output logic                              m_tlast
);
	import rgmb_pkg::*;

	localparam int SEC_M       = CELLS_ACROSS_SECTOR * CELL_METERS;
	localparam int VIEW_M      = SECTORS_ACROSS * SEC_M;
	localparam int SECTOR_CELLS = CELLS_ACROSS_SECTOR * CELLS_ACROSS_SECTOR;
	localparam int STORE_CELLS = SECTORS_ACROSS * SECTORS_ACROSS * SECTOR_CELLS;
	localparam int VW  = $clog2(VIEW_M);
	localparam int CW  = $clog2(SECTORS_ACROSS * CELLS_ACROSS_SECTOR);
	localparam int SW  = $clog2(SECTORS_ACROSS);
	localparam int OW  = $clog2(CELLS_ACROSS_SECTOR);
	localparam int SLW = $clog2(SECTORS_ACROSS * SECTORS_ACROSS);
	localparam int RW  = $clog2(SECTOR_CELLS);
	localparam int AW  = $clog2(STORE_CELLS);
	localparam int LM  = $clog2(CELL_METERS);
	localparam int LC  = $clog2(CELLS_ACROSS_SECTOR);
	// Reciprocals for exact division by a constant over the value range in use.
	localparam longint RECIP_M_L =
		((longint'(1) << (VW + LM)) + longint'(CELL_METERS) - 1) / longint'(CELL_METERS);
	localparam longint RECIP_C_L =
		((longint'(1) << (CW + LC)) + longint'(CELLS_ACROSS_SECTOR) - 1)
		/ longint'(CELLS_ACROSS_SECTOR);
	localparam logic [VW:0] RECIP_M = (VW + 1)'(RECIP_M_L);
	localparam logic [CW:0] RECIP_C = (CW + 1)'(RECIP_C_L);
	localparam logic [31:0] VIEW_OFS = 32'(VIEW_M);
	localparam logic [31:0] SEC_OFS  = 32'(SEC_M);
	localparam logic [31:0] LAST_OFS = 32'((SECTORS_ACROSS - 1) * SEC_M);
	localparam logic [SW-1:0] S_LAST = SW'(SECTORS_ACROSS - 1);

	typedef struct packed {
		logic       kind;
		logic       last;
		logic       wr;
		logic       inv;
		logic [7:0] value;
		swap_t      swap;
	} carry_t;

	// View state and configuration.
	logic [31:0]   vme_q;
	logic [31:0]   vmn_q;
	logic [SW-1:0] ac_q;
	logic [SW-1:0] ar_q;
	logic [7:0]    default_q;

	// Sequencer.
	back_state_t   state_q;
	back_state_t   state_d;
	logic [SW-1:0] cnt_q;
	op_t           scroll_op_q;
	logic [AW-1:0] clr_q;

	logic          adv;
	logic          head_access;
	logic          ins_access;
	logic          ins_swap;
	logic          scroll_end;
	op_t           cur_op;
	logic [SW-1:0] cur_i;
	logic [SW-1:0] ac_prev;
	logic [SW-1:0] ar_prev;
	logic [SW-1:0] lr;
	logic [SW-1:0] lc;
	logic [SW-1:0] sel_sec;
	logic [SLW-1:0] swap_slot;
	swap_t         sw;

	logic [31:0]   de_full;
	logic [31:0]   dn_full;
	logic          inview;

	// Pipeline.
	logic          v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7;
	carry_t        c_s1, c_s2, c_s3, c_s4, c_s5, c_s6, c_s7;
	logic [VW-1:0] de_s1, dn_s1;
	logic [SW-1:0] ac_s1, ar_s1, ac_s2, ar_s2, ac_s3, ar_s3;
	logic [CW-1:0] ce_s2, cn_s2, ce_s3, cn_s3;
	logic [SW-1:0] col_s3, row_s3;
	logic [OW-1:0] offe_s4, offn_s4;
	logic [SW-1:0] pc_s4, pr_s4;
	logic [SLW-1:0] slot_s5;
	logic [RW-1:0] offrow_s5;
	logic [AW-1:0] addr_s6;

	logic [2*VW:0] prod_e, prod_n;
	logic [2*CW:0] prodc_e, prodc_n;
	logic [SW:0]   sum_c, sum_r;
	logic [SW-1:0] pc_w, pr_w;

	// Store.
	logic          ram_we;
	logic          ram_re;
	logic [AW-1:0] ram_waddr;
	logic [7:0]    ram_wdata;
	logic [7:0]    ram_rdata;
	logic [7:0]    out_cell;

	// The pipeline moves as a whole whenever the output register can take a result.
	assign adv         = !v_s7 || m_tready;
	assign head_access = (q_item.op == OP_READ) || (q_item.op == OP_WRITE);
	assign cur_op      = (state_q == BK_SCROLL) ? scroll_op_q : q_item.op;
	assign cur_i       = (state_q == BK_SCROLL) ? cnt_q : '0;
	assign ins_access  = (state_q == BK_RUN) && q_valid && adv && head_access;
	assign ins_swap    = adv && (((state_q == BK_RUN) && q_valid && !head_access)
		|| (state_q == BK_SCROLL));
	assign scroll_end  = ins_swap && (cur_i == S_LAST);

	// Next state and sequencer outputs.
	always_comb begin
		state_d  = state_q;
		q_ready  = 1'b0;
		clearing = 1'b0;
		unique case (state_q)
			BK_CLEAR: begin
				clearing = 1'b1;
				if (clr_q == AW'(STORE_CELLS - 1)) begin
					state_d = BK_RUN;
				end
			end
			BK_RUN: begin
				q_ready = adv;
				if (ins_swap) begin
					state_d = BK_SCROLL;
				end
			end
			BK_SCROLL: begin
				if (scroll_end) begin
					state_d = BK_RUN;
				end
			end
			default: state_d = BK_CLEAR;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= BK_CLEAR;
			cnt_q       <= '0;
			clr_q       <= '0;
			scroll_op_q <= OP_EAST;
		end else begin
			state_q <= state_d;
			if (state_q == BK_CLEAR) begin
				clr_q <= clr_q + AW'(1);
			end
			if (ins_swap) begin
				cnt_q <= cur_i + SW'(1);
			end
			if ((state_q == BK_RUN) && ins_swap) begin
				scroll_op_q <= q_item.op;
			end
		end
	end

	// Swap request fields for the current sector of a scroll.
	always_comb begin
		ac_prev = (ac_q == '0) ? S_LAST : ac_q - SW'(1);
		ar_prev = (ar_q == '0) ? S_LAST : ar_q - SW'(1);
		lr = (cur_i >= ar_q) ? cur_i - ar_q
			: SW'((SW + 1)'(cur_i) + (SW + 1)'(SECTORS_ACROSS) - (SW + 1)'(ar_q));
		lc = (cur_i >= ac_q) ? cur_i - ac_q
			: SW'((SW + 1)'(cur_i) + (SW + 1)'(SECTORS_ACROSS) - (SW + 1)'(ac_q));
		sw      = '0;
		sel_sec = '0;
		swap_slot = '0;
		case (cur_op)
			OP_EAST: begin
				sel_sec       = ac_q;
				sw.save_east  = vme_q;
				sw.load_east  = vme_q + VIEW_OFS;
				sw.save_north = vmn_q + 32'(lr) * SEC_OFS;
				sw.load_north = sw.save_north;
				swap_slot = SLW'(SLW'(cur_i) * SLW'(SECTORS_ACROSS) + SLW'(sel_sec));
			end
			OP_WEST: begin
				sel_sec       = ac_prev;
				sw.save_east  = vme_q + LAST_OFS;
				sw.load_east  = vme_q - SEC_OFS;
				sw.save_north = vmn_q + 32'(lr) * SEC_OFS;
				sw.load_north = sw.save_north;
				swap_slot = SLW'(SLW'(cur_i) * SLW'(SECTORS_ACROSS) + SLW'(sel_sec));
			end
			OP_NORTH: begin
				sel_sec       = ar_q;
				sw.save_north = vmn_q;
				sw.load_north = vmn_q + VIEW_OFS;
				sw.save_east  = vme_q + 32'(lc) * SEC_OFS;
				sw.load_east  = sw.save_east;
				swap_slot = SLW'(SLW'(sel_sec) * SLW'(SECTORS_ACROSS) + SLW'(cur_i));
			end
			OP_SOUTH: begin
				sel_sec       = ar_prev;
				sw.save_north = vmn_q + LAST_OFS;
				sw.load_north = vmn_q - SEC_OFS;
				sw.save_east  = vme_q + 32'(lc) * SEC_OFS;
				sw.load_east  = sw.save_east;
				swap_slot = SLW'(SLW'(sel_sec) * SLW'(SECTORS_ACROSS) + SLW'(cur_i));
			end
			default: begin
				sel_sec = '0;
			end
		endcase
		sw.slot = 8'(swap_slot);
	end

	// Configuration writes and the view step at the end of a scroll.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vme_q     <= '0;
			vmn_q     <= '0;
			ac_q      <= '0;
			ar_q      <= '0;
			default_q <= '0;
		end else if (cfg_wen) begin
			case (cfg_index)
				CFG_ORIGIN_EAST:   vme_q     <= cfg_data;
				CFG_ORIGIN_NORTH:  vmn_q     <= cfg_data;
				CFG_DEFAULT_VALUE: default_q <= cfg_data[7:0];
				default: ;
			endcase
		end else if (scroll_end) begin
			case (cur_op)
				OP_EAST: begin
					ac_q  <= (ac_q == S_LAST) ? '0 : ac_q + SW'(1);
					vme_q <= vme_q + SEC_OFS;
				end
				OP_WEST: begin
					ac_q  <= ac_prev;
					vme_q <= vme_q - SEC_OFS;
				end
				OP_NORTH: begin
					ar_q  <= (ar_q == S_LAST) ? '0 : ar_q + SW'(1);
					vmn_q <= vmn_q + SEC_OFS;
				end
				OP_SOUTH: begin
					ar_q  <= ar_prev;
					vmn_q <= vmn_q - SEC_OFS;
				end
				default: ;
			endcase
		end
	end

	// View test on the wrapped distance from the view minimum.
	assign de_full = q_item.easting - vme_q;
	assign dn_full = q_item.northing - vmn_q;
	assign inview  = (de_full < VIEW_OFS) && (dn_full < VIEW_OFS);

	// Divisions by constants through reciprocal multiplication.
	assign prod_e  = (2 * VW + 1)'(de_s1) * (2 * VW + 1)'(RECIP_M);
	assign prod_n  = (2 * VW + 1)'(dn_s1) * (2 * VW + 1)'(RECIP_M);
	assign prodc_e = (2 * CW + 1)'(ce_s2) * (2 * CW + 1)'(RECIP_C);
	assign prodc_n = (2 * CW + 1)'(cn_s2) * (2 * CW + 1)'(RECIP_C);

	// Physical sector column and row on the torus.
	assign sum_c = (SW + 1)'(col_s3) + (SW + 1)'(ac_s3);
	assign sum_r = (SW + 1)'(row_s3) + (SW + 1)'(ar_s3);
	assign pc_w  = (sum_c >= (SW + 1)'(SECTORS_ACROSS))
		? SW'(sum_c - (SW + 1)'(SECTORS_ACROSS)) : SW'(sum_c);
	assign pr_w  = (sum_r >= (SW + 1)'(SECTORS_ACROSS))
		? SW'(sum_r - (SW + 1)'(SECTORS_ACROSS)) : SW'(sum_r);

	// Stage valid bits.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
		end else if (adv) begin
			v_s1 <= ins_access || ins_swap;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
			v_s7 <= v_s6;
		end
	end

	// Stage payload.
	always_ff @(posedge clk) begin
		if (adv) begin
			if (ins_swap) begin
				c_s1.kind  <= KIND_SWAP;
				c_s1.last  <= cur_i == S_LAST;
				c_s1.wr    <= 1'b0;
				c_s1.inv   <= 1'b0;
				c_s1.value <= '0;
				c_s1.swap  <= sw;
			end else begin
				c_s1.kind  <= KIND_ACCESS;
				c_s1.last  <= 1'b1;
				c_s1.wr    <= q_item.op == OP_WRITE;
				c_s1.inv   <= inview;
				c_s1.value <= !inview ? default_q
					: ((q_item.op == OP_WRITE) ? q_item.value : 8'd0);
				c_s1.swap  <= '0;
			end
			de_s1 <= de_full[VW-1:0];
			dn_s1 <= dn_full[VW-1:0];
			ac_s1 <= ac_q;
			ar_s1 <= ar_q;

			c_s2  <= c_s1;
			ce_s2 <= prod_e[VW + LM +: CW];
			cn_s2 <= prod_n[VW + LM +: CW];
			ac_s2 <= ac_s1;
			ar_s2 <= ar_s1;

			c_s3   <= c_s2;
			col_s3 <= prodc_e[CW + LC +: SW];
			row_s3 <= prodc_n[CW + LC +: SW];
			ce_s3  <= ce_s2;
			cn_s3  <= cn_s2;
			ac_s3  <= ac_s2;
			ar_s3  <= ar_s2;

			c_s4    <= c_s3;
			offe_s4 <= OW'(ce_s3 - CW'(col_s3) * CW'(CELLS_ACROSS_SECTOR));
			offn_s4 <= OW'(cn_s3 - CW'(row_s3) * CW'(CELLS_ACROSS_SECTOR));
			pc_s4   <= pc_w;
			pr_s4   <= pr_w;

			c_s5      <= c_s4;
			slot_s5   <= SLW'(SLW'(pr_s4) * SLW'(SECTORS_ACROSS) + SLW'(pc_s4));
			offrow_s5 <= RW'(RW'(offn_s4) * RW'(CELLS_ACROSS_SECTOR) + RW'(offe_s4));

			c_s6    <= c_s5;
			addr_s6 <= AW'(AW'(slot_s5) * AW'(SECTOR_CELLS) + AW'(offrow_s5));

			c_s7 <= c_s6;
		end
	end

	// Store port control: the clearing sweep writes the reset value everywhere.
	assign ram_re    = adv && v_s6 && c_s6.inv && !c_s6.wr;
	assign ram_we    = clearing || (adv && v_s6 && c_s6.inv && c_s6.wr);
	assign ram_waddr = clearing ? clr_q : addr_s6;
	assign ram_wdata = clearing ? 8'd0 : c_s6.value;

	rgmb_ram #(
		.WIDTH (8),
		.DEPTH (STORE_CELLS)
	) u_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (addr_s6),
		.rdata (ram_rdata)
	);

	// Output register drive.
	assign out_cell = (c_s7.inv && !c_s7.wr) ? ram_rdata : c_s7.value;
	assign m_tvalid = v_s7;
	assign m_tuser  = c_s7.kind;
	assign m_tlast  = c_s7.last;
	assign m_tdata  = {7'd0, c_s7.swap.load_north, c_s7.swap.load_east,
		c_s7.swap.save_north, c_s7.swap.save_east, c_s7.swap.slot, c_s7.inv, out_cell};

`ifndef SYNTHESIS
	a_no_result_while_clearing: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == BK_CLEAR) |-> !m_tvalid)
		else $error("result presented during the clearing sweep");
	a_store_one_access: assert property (@(posedge clk) disable iff (!arst_n)
		!(ram_we && ram_re))
		else $error("store read and written in the same cycle");
	a_scroll_count: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == BK_SCROLL) |-> (cnt_q != '0) && (cnt_q <= S_LAST))
		else $error("scroll sector counter out of range");
	a_anchor_range: assert property (@(posedge clk) disable iff (!arst_n)
		(ac_q <= S_LAST) && (ar_q <= S_LAST))
		else $error("anchor outside the sector count");
	a_scroll_returns: assert property (@(posedge clk) disable iff (!arst_n)
		scroll_end |=> (state_q == BK_RUN))
		else $error("sequencer did not return after the last swap request");
`endif

endmodule

/* hdl/rolling_grid_map_buffer.sv */
// Top level of the rolling grid map buffer: front end, item queue and back end.
// Depends on rgmb_pkg, rgmb_front, rgmb_queue, rgmb_back and rgmb_ram.
//
// Channel   Direction  Handshake           Contents
// s_*       in         s_tvalid/s_tready   tuser mode, tdata easting/northing/value
// m_*       out        m_tvalid/m_tready   tuser kind, tdata answer or swap, tlast
// cfg_*     in         cfg_wen             origin_east, origin_north, default_value
//
// Reads and writes go one per cycle unless a scroll runs or m_tready holds the pipeline;
// each answer passes the address pipeline (two reciprocal multiplies, torus wrap, address build).
// A scroll issues SECTORS_ACROSS swap requests, one per cycle while the pipeline advances, from the back-end sequencer.
// After reset a clearing pass writes every cell, SECTORS_ACROSS^2 * CELLS_ACROSS_SECTOR^2
// cells (65536 at the defaults); s_tready stays low until it ends.
// When m_tready is low the pipeline holds; the front end and queue still take items until the queue fills.
module rolling_grid_map_buffer #(
	parameter int SECTORS_ACROSS      = 4,
	parameter int CELLS_ACROSS_SECTOR = 64,
	parameter int CELL_METERS         = 1
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_wen,
	input  logic [rgmb_pkg::CFG_INDEX_W-1:0]  cfg_index,
	input  logic [rgmb_pkg::CFG_DATA_W-1:0]   cfg_data,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	input  logic [2:0]                        s_tuser,  // mode
	input  logic [rgmb_pkg::IN_TDATA_W-1:0]   s_tdata,  // easting, northing, value
	output logic                              m_tvalid,
	input  logic                              m_tready,
	output logic                              m_tuser,  // kind
	// cell_value, in_view, sector_slot, save_east, save_north, load_east, load_north
	output logic [rgmb_pkg::OUT_TDATA_W-1:0]  m_tdata,
	output logic                              m_tlast
);
	import rgmb_pkg::*;

	logic  clearing;
	logic  f_valid;
	logic  f_ready;
	item_t f_item;
	logic  b_valid;
	logic  b_ready;
	item_t b_item;

	rgmb_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.clearing (clearing),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tuser  (s_tuser),
		.s_tdata  (s_tdata),
		.q_valid  (f_valid),
		.q_ready  (f_ready),
		.q_item   (f_item)
	);

	rgmb_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (f_valid),
		.in_ready  (f_ready),
		.in_item   (f_item),
		.out_valid (b_valid),
		.out_ready (b_ready),
		.out_item  (b_item)
	);

	rgmb_back #(
		.SECTORS_ACROSS      (SECTORS_ACROSS),
		.CELLS_ACROSS_SECTOR (CELLS_ACROSS_SECTOR),
		.CELL_METERS         (CELL_METERS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wen   (cfg_wen),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.q_valid   (b_valid),
		.q_ready   (b_ready),
		.q_item    (b_item),
		.clearing  (clearing),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tuser   (m_tuser),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast)
	);

endmodule
